// ===== design/ghse_pkg.sv =====
package ghse_pkg;

    localparam int MAX_SECRET_BYTES_DEF = 256;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_EVAL_POINT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFF_COUNT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SECRET_LENGTH = 2'd2;

    // x^8 + x^4 + x^3 + x + 1
    localparam logic [8:0] GF_REDUCE = 9'h11B;

    // One coefficient on its way from the counter stage to the accumulator update.
    typedef struct packed {
        logic       first;
        logic       emit;
        logic       last;
        logic [7:0] coeff;
    } item_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                r = r ^ p;
            end
            p = p[7] ? ((p << 1) ^ GF_REDUCE[7:0]) : (p << 1);
        end
        return r;
    endfunction

endpackage

// ===== design/ghse_acc_mem.sv =====
module ghse_acc_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read that meets a write to the same entry in the same cycle returns the new value.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ghse_ctrl.sv =====
module ghse_ctrl #(
    parameter int MAX_SECRET_BYTES = ghse_pkg::MAX_SECRET_BYTES_DEF,
    localparam int PosW = (MAX_SECRET_BYTES > 1) ? $clog2(MAX_SECRET_BYTES) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ghse_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ghse_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               take,
    input  logic [7:0]                         coefficient,
    output logic                               issue,
    output ghse_pkg::item_t                    item,
    output logic [PosW-1:0]                    pos,
    output logic [7:0]                         eval_point
);

    import ghse_pkg::*;

    logic [7:0]      eval_point_reg;
    logic [7:0]      coeff_count_reg;
    logic [8:0]      secret_length_reg;
    logic [PosW-1:0] pos_reg;
    logic [PosW-1:0] pos_next;
    logic [7:0]      deg_reg;
    logic [7:0]      deg_next;

    logic [8:0]      len_eff;
    logic            drop;
    logic            wrap;
    logic [PosW-1:0] pos_cur;
    logic [7:0]      deg_cur;
    logic [PosW:0]   pos_inc;
    logic [8:0]      deg_inc;
    logic            pos_wrap;

    always_comb
    begin
        if (32'(secret_length_reg) > 32'(MAX_SECRET_BYTES))
        begin
            len_eff = 9'(MAX_SECRET_BYTES);
        end
        else
        begin
            len_eff = secret_length_reg;
        end
    end

    assign drop = (coeff_count_reg == 8'd0) || (len_eff == 9'd0);

    // Counters left out of range by a register change restart a new polynomial.
    assign wrap    = (32'(pos_reg) >= 32'(len_eff)) || (deg_reg >= coeff_count_reg);
    assign pos_cur = wrap ? '0 : pos_reg;
    assign deg_cur = wrap ? 8'd0 : deg_reg;

    assign pos_inc  = {1'b0, pos_cur} + (PosW+1)'(1);
    assign deg_inc  = {1'b0, deg_cur} + 9'd1;
    assign pos_wrap = 32'(pos_inc) >= 32'(len_eff);

    always_comb
    begin
        pos_next = pos_reg;
        deg_next = deg_reg;
        if (take && !drop)
        begin
            if (pos_wrap)
            begin
                pos_next = '0;
                deg_next = (deg_inc >= {1'b0, coeff_count_reg}) ? 8'd0 : deg_inc[7:0];
            end
            else
            begin
                pos_next = pos_inc[PosW-1:0];
                deg_next = deg_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_point_reg    <= 8'd1;
            coeff_count_reg   <= 8'd1;
            secret_length_reg <= 9'd1;
            pos_reg           <= '0;
            deg_reg           <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            deg_reg <= deg_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_EVAL_POINT:    eval_point_reg    <= cfg_data[7:0];
                    REG_COEFF_COUNT:   coeff_count_reg   <= cfg_data[7:0];
                    REG_SECRET_LENGTH: secret_length_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    assign issue      = take && !drop;
    assign item.first = (deg_cur == 8'd0);
    assign item.emit  = (deg_cur == (coeff_count_reg - 8'd1));
    assign item.last  = (32'(pos_cur) == (32'(len_eff) - 32'd1));
    assign item.coeff = coefficient;
    assign pos        = pos_cur;
    assign eval_point = eval_point_reg;

    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue && !cfg_we |=> (32'(pos_reg) < 32'(len_eff)) && (deg_reg < coeff_count_reg))
        else $error("position or degree counter out of range after an accepted beat");

    a_polynomial_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        issue && item.emit && item.last && !cfg_we |=> (pos_reg == '0) && (deg_reg == 8'd0))
        else $error("counters did not restart after the final beat of a polynomial");

endmodule

// ===== design/gf256_horner_share_evaluator_core.sv =====
// Each coefficient beat first reads its accumulator entry; the update stage then
// writes back acc*eval_point xor coefficient (the coefficient alone on a first beat).
// Throughput is one beat per cycle while the share output is not back-pressured; a
// one-entry write bypass in the accumulator memory covers back-to-back beats on the
// same position. Reset (rst_n, asynchronous, active low) sets eval_point, coeff_count and
// secret_length to 1 and clears the counters; accumulator contents are not reset.
module gf256_horner_share_evaluator_core #(
    parameter int MAX_SECRET_BYTES = ghse_pkg::MAX_SECRET_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ghse_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ghse_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] coefficient
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // [7:0] share_byte, [15:8] byte_position
    output logic                               m_tlast    // final_byte
);

    import ghse_pkg::*;

    localparam int PosW = (MAX_SECRET_BYTES > 1) ? $clog2(MAX_SECRET_BYTES) : 1;

    logic            take;
    logic            issue;
    item_t           item;
    logic [PosW-1:0] pos;
    logic [7:0]      eval_point;
    logic [7:0]      rd_data;

    logic            s1_valid_reg;
    logic            s1_valid_next;
    item_t           s1_item_reg;
    logic [PosW-1:0] s1_pos_reg;
    logic            s1_adv;
    logic            s1_fire;
    logic [7:0]      acc_new;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [7:0]      out_share_reg;
    logic [7:0]      out_pos_reg;
    logic            out_last_reg;

    assign cfg_ready = 1'b1;

    assign s1_adv   = !s1_item_reg.emit || !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign take     = s_tvalid && s_tready;
    assign s1_fire  = s1_valid_reg && s1_adv;

    ghse_ctrl #(
        .MAX_SECRET_BYTES (MAX_SECRET_BYTES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .take        (take),
        .coefficient (s_tdata),
        .issue       (issue),
        .item        (item),
        .pos         (pos),
        .eval_point  (eval_point)
    );

    ghse_acc_mem #(
        .DEPTH (MAX_SECRET_BYTES),
        .AW    (PosW)
    ) u_acc_mem (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_pos_reg),
        .wr_data (acc_new),
        .rd_en   (issue),
        .rd_addr (pos),
        .rd_data (rd_data)
    );

    assign acc_new = s1_item_reg.first ? s1_item_reg.coeff
                                       : (gf_mul(rd_data, eval_point) ^ s1_item_reg.coeff);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_item_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_item_reg <= item;
            s1_pos_reg  <= pos;
        end
        if (s1_fire && s1_item_reg.emit)
        begin
            out_share_reg <= acc_new;
            out_pos_reg   <= 8'(s1_pos_reg);
            out_last_reg  <= s1_item_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pos_reg, out_share_reg};
    assign m_tlast  = out_last_reg;

    a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> $stable(rd_data) && $stable(s1_pos_reg))
        else $error("accumulator read data changed while the update stage was stalled");

    a_no_issue_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |-> !issue)
        else $error("new beat issued while the update stage was stalled");

    a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !(s1_fire && s1_item_reg.emit))
        else $error("pending result overwritten before it was taken");

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ghse_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 850;
    localparam int SETTLE_CYCLES = 8;
    localparam int RESET_CYCLES  = 12;
    localparam int CAPACITY      = 256;

    // The index that maps to no register; writes to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] share;
        logic [7:0] pos;
        logic       last;
    } share_beat_t;

    typedef enum bit [1:0] {
        ROW_REG,
        ROW_COEF,
        ROW_COEF_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [7:0]             coeff;
        bit                     has_share;
        logic [7:0]             share;
        logic [7:0]             pos;
        logic                   last;
    } stim_row_t;

    // Rows of kind ROW_COEF_KNOWN carry their result (or its absence) typed in.
    localparam stim_row_t DIRECTED [39] = '{
        '{ROW_REG,        REG_UNUSED,        9'h1FF, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF_KNOWN, '0,                '0,     8'h00, 1'b1, 8'h00, 8'h00, 1'b1},
        '{ROW_COEF_KNOWN, '0,                '0,     8'hFF, 1'b1, 8'hFF, 8'h00, 1'b1},
        '{ROW_REG,        REG_SECRET_LENGTH, 9'd0,   8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF_KNOWN, '0,                '0,     8'h3C, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_REG,        REG_SECRET_LENGTH, 9'd3,   8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_REG,        REG_COEFF_COUNT,   9'd0,   8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF_KNOWN, '0,                '0,     8'h11, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_REG,        REG_COEFF_COUNT,   9'd2,   8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_REG,        REG_EVAL_POINT,    9'd0,   8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h12, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h34, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h56, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF_KNOWN, '0,                '0,     8'hFF, 1'b1, 8'hFF, 8'h00, 1'b0},
        '{ROW_COEF_KNOWN, '0,                '0,     8'h80, 1'b1, 8'h80, 8'h01, 1'b0},
        '{ROW_COEF_KNOWN, '0,                '0,     8'h01, 1'b1, 8'h01, 8'h02, 1'b1},
        '{ROW_REG,        REG_EVAL_POINT,    9'hFF,  8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_REG,        REG_SECRET_LENGTH, 9'd2,   8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h01, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h80, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'hFF, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h1B, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_REG,        REG_EVAL_POINT,    9'h02,  8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_REG,        REG_COEFF_COUNT,   9'd3,   8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h57, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h83, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h13, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_REG,        REG_COEFF_COUNT,   9'd1,   8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF_KNOWN, '0,                '0,     8'h9A, 1'b1, 8'h9A, 8'h00, 1'b0},
        '{ROW_COEF_KNOWN, '0,                '0,     8'h01, 1'b1, 8'h01, 8'h01, 1'b1},
        '{ROW_REG,        REG_COEFF_COUNT,   9'd2,   8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_REG,        REG_SECRET_LENGTH, 9'd4,   8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h21, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h22, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h23, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_REG,        REG_SECRET_LENGTH, 9'd2,   8'h00, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h44, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h45, 1'b0, 8'h00, 8'h00, 1'b0},
        '{ROW_COEF,       '0,                '0,     8'h46, 1'b0, 8'h00, 8'h00, 1'b0}
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [15:0]            m_tdata;
    logic                   m_tlast;

    int cycles         = 0;
    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Predictor state: register copies, the per-position accumulators, the counters.
    logic [7:0]  pt_eval;
    logic [7:0]  pt_count;
    logic [8:0]  pt_length;
    logic [7:0]  acc_mem [CAPACITY];
    int          at_pos;
    int          at_deg;
    share_beat_t due_shares [$];

    gf256_horner_share_evaluator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic flag(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    // Multiply from the top bit down: double the partial product, then add a.
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[6:0], 1'b0} ^ (r[7] ? GF_REDUCE[7:0] : 8'h00);
            if (b[i])
            begin
                r = r ^ a;
            end
        end
        return r;
    endfunction

    function automatic void horner_clear();
        pt_eval   = 8'd1;
        pt_count  = 8'd1;
        pt_length = 9'd1;
        for (int i = 0; i < CAPACITY; i++)
        begin
            acc_mem[i] = '0;
        end
        at_pos = 0;
        at_deg = 0;
    endfunction

    function automatic bit horner_step(input logic [7:0] c, output share_beat_t r);
        int span;
        int cnt;
        bit emits;
        span  = (pt_length > CAPACITY) ? CAPACITY : int'(pt_length);
        cnt   = int'(pt_count);
        emits = 1'b0;
        r     = '0;
        if (cnt == 0 || span == 0)
        begin
            return 1'b0;
        end
        // A counter beyond a bound that shrank mid-stream starts a fresh polynomial.
        if (at_pos >= span || at_deg >= cnt)
        begin
            at_pos = 0;
            at_deg = 0;
        end
        if (at_deg == 0)
        begin
            acc_mem[at_pos] = c;
        end
        else
        begin
            acc_mem[at_pos] = gf_times(acc_mem[at_pos], pt_eval) ^ c;
        end
        if (at_deg == cnt - 1)
        begin
            r.share = acc_mem[at_pos];
            r.pos   = at_pos[7:0];
            r.last  = (at_pos == span - 1);
            emits   = 1'b1;
        end
        at_pos++;
        if (at_pos >= span)
        begin
            at_pos = 0;
            at_deg++;
            if (at_deg >= cnt)
            begin
                at_deg = 0;
            end
        end
        return emits;
    endfunction

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_shares.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Beats that produce no share may still be in the pipeline, so let it settle.
    task automatic wait_idle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_EVAL_POINT:    pt_eval   = data[7:0];
            REG_COEFF_COUNT:   pt_count  = data[7:0];
            REG_SECRET_LENGTH: pt_length = data;
            default: ;
        endcase
    endtask

    task automatic push_coeff(input logic [7:0] c, input bit known,
                              input share_beat_t want, input bit want_has);
        int gap;
        bit has;
        share_beat_t got;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        has = horner_step(c, got);
        if (known)
        begin
            has = want_has;
            got = want;
        end
        if (has)
        begin
            due_shares.push_back(got);
        end
    endtask

    always @(posedge clk)
    begin : share_monitor
        share_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_shares.size() == 0)
            begin
                flag($sformatf("unexpected share %h at position %0d",
                               m_tdata[7:0], m_tdata[15:8]));
            end
            else
            begin
                want = due_shares.pop_front();
                if (m_tdata[7:0] !== want.share)
                begin
                    flag($sformatf("share byte %h, wanted %h at position %0d",
                                   m_tdata[7:0], want.share, want.pos));
                end
                if (m_tdata[15:8] !== want.pos)
                begin
                    flag($sformatf("byte position %0d, wanted %0d", m_tdata[15:8], want.pos));
                end
                if (m_tlast !== want.last)
                begin
                    flag($sformatf("last flag %b, wanted %b at position %0d",
                                   m_tlast, want.last, want.pos));
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin : stimulus
        share_beat_t want;
        int done;
        int phase;
        int cnt;
        int span;
        int polys;
        int partial;
        int n_items;
        bit dropped;
        logic [CFG_DATA_W-1:0] eval_data;
        logic [CFG_DATA_W-1:0] len_data;

        horner_clear();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            if (DIRECTED[i].kind == ROW_REG)
            begin
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            end
            else
            begin
                want = '{DIRECTED[i].share, DIRECTED[i].pos, DIRECTED[i].last};
                push_coeff(DIRECTED[i].coeff, DIRECTED[i].kind == ROW_COEF_KNOWN,
                           want, DIRECTED[i].has_share);
            end
        end

        // The first random phase fills every accumulator entry, so later phases may
        // break off mid-polynomial and change registers without reading stale entries.
        done  = 0;
        phase = 0;
        while (done < RANDOM_ITEMS)
        begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            endcase
            case ($urandom_range(0, 5))
                0:       eval_data = 9'h000;
                1:       eval_data = 9'h0FF;
                2:       eval_data = 9'h101;
                default: eval_data = 9'($urandom);
            endcase
            dropped = 1'b0;
            polys   = 1;
            partial = 0;
            case (phase)
                0:
                begin
                    cnt      = 1;
                    len_data = 9'd511;
                end
                1:
                begin
                    cnt      = 255;
                    len_data = 9'd1;
                end
                2:
                begin
                    cnt      = 1;
                    len_data = 9'd256;
                    polys    = 0;
                    partial  = 40;
                end
                default:
                begin
                    cnt      = $urandom_range(1, 6);
                    len_data = 9'($urandom_range(1, 16));
                    polys    = $urandom_range(1, 3);
                    if ($urandom_range(0, 4) == 0)
                    begin
                        partial = $urandom_range(0, cnt * int'(len_data) - 1);
                    end
                    if ($urandom_range(0, 7) == 0)
                    begin
                        dropped = 1'b1;
                        polys   = 0;
                        partial = $urandom_range(3, 8);
                        if ($urandom_range(0, 1) == 0)
                        begin
                            cnt = 0;
                        end
                        else
                        begin
                            len_data = '0;
                        end
                    end
                end
            endcase
            write_reg(REG_EVAL_POINT, eval_data);
            write_reg(REG_COEFF_COUNT, {1'($urandom_range(0, 1)), 8'(cnt)});
            write_reg(REG_SECRET_LENGTH, len_data);
            if ($urandom_range(0, 5) == 0)
            begin
                write_reg(REG_UNUSED, 9'($urandom));
            end
            span    = (len_data > CAPACITY) ? CAPACITY : int'(len_data);
            n_items = polys * cnt * span + partial;
            for (int k = 0; k < n_items; k++)
            begin
                push_coeff(8'($urandom), 1'b0, '0, 1'b0);
                if (phase % 5 == 3 && k == n_items / 2)
                begin
                    hold_until_drained();
                end
            end
            if (!dropped)
            begin
                done += n_items;
            end
            phase++;
        end

        hold_until_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_shares.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== gf256_horner_share_evaluator_core.f =====
design/ghse_pkg.sv
design/ghse_acc_mem.sv
design/ghse_ctrl.sv
design/gf256_horner_share_evaluator_core.sv
dv/tb.sv
